[hw/rtl/tdu_pkg.sv]
// tdu_pkg: shared types and constants for the tick driven uart
// operation codes, register indexes, frame config and result structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tdu_pkg;

    localparam int FIFO_DEPTH_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DATA_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_BITS = 2'd1;

    localparam logic [3:0] DATA_BITS_RST = 4'd8;
    localparam logic [1:0] STOP_BITS_RST = 2'd1;
    localparam logic [3:0] DATA_BITS_MIN = 4'd5;
    localparam logic [3:0] DATA_BITS_MAX = 4'd8;
    localparam logic [1:0] STOP_BITS_MIN = 2'd1;
    localparam logic [1:0] STOP_BITS_MAX = 2'd2;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_EDGE = 2'd1,
        OP_PUSH = 2'd2
    } op_t;

    typedef struct packed {
        logic [3:0] nd;
        logic [3:0] frame;
    } frame_cfg_t;

    typedef struct packed {
        logic tick;
        logic edge_ev;
        logic push;
    } ev_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       edge_ok;
    } rx_res_t;

    typedef struct packed {
        logic line;
        logic busy;
        logic push_ok;
    } tx_res_t;

endpackage

`default_nettype wire

[hw/rtl/tdu_ram.sv]
// tdu_ram: transmit queue storage, one write and one registered read port
// write-first bypass when both ports hit the same entry
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tdu_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 8
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (we && (waddr == raddr)) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/tdu_rx.sv]
// tdu_rx: receive half, arms on a falling edge and samples on ticks
// depends on tdu_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdu_rx
    import tdu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire frame_cfg_t cfg,
    input  wire ev_t        ev,
    input  wire logic       rx_level,
    output rx_res_t         res
);

    logic       armed_reg, armed_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [7:0] shift_reg, shift_next;
    logic [3:0] cnt_inc;
    logic [7:0] aligned;

    assign cnt_inc = cnt_reg + 4'd1;

    always_comb begin
        case (cfg.nd)
            4'd5:    aligned = {3'b000, shift_reg[7:3]};
            4'd6:    aligned = {2'b00, shift_reg[7:2]};
            4'd7:    aligned = {1'b0, shift_reg[7:1]};
            default: aligned = shift_reg;
        endcase
    end

    always_comb begin
        armed_next = armed_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        res        = '0;
        if (ev.tick && armed_reg) begin
            if (cnt_inc >= cfg.frame) begin
                res.valid  = 1'b1;
                res.data   = aligned;
                armed_next = 1'b0;
                cnt_next   = 4'd0;
            end else begin
                cnt_next = cnt_inc;
                if (cnt_inc <= cfg.nd + 4'd1) begin
                    shift_next = {rx_level, shift_reg[7:1]};
                end
            end
        end else if (ev.edge_ev && !armed_reg) begin
            armed_next  = 1'b1;
            cnt_next    = 4'd0;
            shift_next  = 8'd0;
            res.edge_ok = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
            cnt_reg   <= 4'd0;
            shift_reg <= 8'd0;
        end else begin
            armed_reg <= armed_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tdu_tx.sv]
// tdu_tx: transmit half with queue pointers around tdu_ram
// the head entry is prefetched so a tick can pop it at once
// depends on tdu_pkg and tdu_ram
`timescale 1ns / 1ps
`default_nettype none

module tdu_tx
    import tdu_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire frame_cfg_t cfg,
    input  wire ev_t        ev,
    input  wire logic [7:0] push_data,
    output tx_res_t         res
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int FW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR  = AW'(FIFO_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(FIFO_DEPTH);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [7:0]    shift_reg, shift_next;
    logic          line_reg, line_next;
    logic          active_reg, active_next;
    logic [7:0]    head_data;
    logic          push_ok;

    assign push_ok = ev.push && (fill_reg != FULL_FILL);

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        line_next   = line_reg;
        active_next = active_reg;
        if (ev.tick) begin
            if (cnt_reg == 4'd0) begin
                if (fill_reg != '0) begin
                    shift_next  = head_data;
                    head_next   = (head_reg == LAST_PTR) ? '0 : head_reg + AW'(1);
                    fill_next   = fill_reg - FW'(1);
                    line_next   = 1'b0;
                    active_next = 1'b1;
                    cnt_next    = 4'd1;
                end
            end else if (cnt_reg <= cfg.frame - 4'd1) begin
                line_next  = (cnt_reg <= cfg.nd) ? shift_reg[0] : 1'b1;
                shift_next = {1'b1, shift_reg[7:1]};
                cnt_next   = cnt_reg + 4'd1;
            end else begin
                line_next   = 1'b1;
                active_next = 1'b0;
                cnt_next    = 4'd0;
            end
        end else if (push_ok) begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + AW'(1);
            fill_next = fill_reg + FW'(1);
        end
    end

    tdu_ram #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW),
        .DW    (8)
    ) u_ram (
        .aclk  (aclk),
        .we    (push_ok),
        .waddr (tail_reg),
        .wdata (push_data),
        .raddr (head_next),
        .rdata (head_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            cnt_reg    <= 4'd0;
            shift_reg  <= BYTE_ONES;
            line_reg   <= 1'b1;
            active_reg <= 1'b0;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            cnt_reg    <= cnt_next;
            shift_reg  <= shift_next;
            line_reg   <= line_next;
            active_reg <= active_next;
        end
    end

    assign res.line    = line_next;
    assign res.busy    = active_next;
    assign res.push_ok = push_ok;

endmodule

`default_nettype wire

[hw/rtl/tick_driven_uart_with_tx_queue.sv]
// tick_driven_uart_with_tx_queue: bit-tick uart with a transmit queue
// usage:
//   s_ channel carries one word per event: a bit tick, an rx falling edge
//   or a byte to push into the transmit queue. every accepted word gives
//   exactly one m_ word with the line level, busy, received byte and flags.
//   cfg channel writes data_bits (index 0) and stop_bits (index 1); the user
//   writes while the block is idle (not enforced); cfg_ready is always high.
// result and throughput:
//   the result word is registered, valid in the cycle after the input word is
//   accepted; one word is taken every cycle unless a result waits on m_ready.
//   the queue head is read from a memory with a registered read port and is
//   prefetched, so a tick pops it with no wait; a push to that entry is bypassed.
// reset:
//   synchronous, active low. counters, pointers and the output valid flag
//   clear, the tx line idles high, frame config returns to 8 data bits and
//   1 stop bit. queue memory contents are not cleared and need no sweep.
// stall:
//   while m_ready is low a waiting result holds and s_ready drops; a new
//   word is taken in the same cycle the waiting result leaves.
// depends on tdu_pkg, tdu_rx, tdu_tx, tdu_ram
`timescale 1ns / 1ps
`default_nettype none

module tick_driven_uart_with_tx_queue
    import tdu_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_operation,
    input  wire logic                  s_rx_level,
    input  wire logic [7:0]            s_push_data,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_tx_level,
    output logic                       m_tx_busy,
    output logic                       m_rx_valid,
    output logic [7:0]                 m_rx_byte,
    output logic                       m_edge_accepted,
    output logic                       m_push_accepted
);

    logic [3:0] data_bits_reg;
    logic [1:0] stop_bits_reg;
    logic [3:0] nd;
    logic [1:0] ns;
    frame_cfg_t cfg;
    ev_t        ev;
    rx_res_t    rx_res;
    tx_res_t    tx_res;
    logic       accept;

    logic       m_valid_reg, m_valid_next;
    logic       tx_level_reg, tx_busy_reg, rx_valid_reg;
    logic [7:0] rx_byte_reg;
    logic       edge_ok_reg, push_ok_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_bits_reg <= DATA_BITS_RST;
            stop_bits_reg <= STOP_BITS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DATA_BITS: data_bits_reg <= cfg_data;
                REG_STOP_BITS: stop_bits_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (data_bits_reg < DATA_BITS_MIN) begin
            nd = DATA_BITS_MIN;
        end else if (data_bits_reg > DATA_BITS_MAX) begin
            nd = DATA_BITS_MAX;
        end else begin
            nd = data_bits_reg;
        end
        if (stop_bits_reg < STOP_BITS_MIN) begin
            ns = STOP_BITS_MIN;
        end else if (stop_bits_reg > STOP_BITS_MAX) begin
            ns = STOP_BITS_MAX;
        end else begin
            ns = stop_bits_reg;
        end
    end

    assign cfg.nd    = nd;
    assign cfg.frame = 4'd1 + nd + {2'b00, ns};

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign ev.tick    = accept && (s_operation == OP_TICK);
    assign ev.edge_ev = accept && (s_operation == OP_EDGE);
    assign ev.push    = accept && (s_operation == OP_PUSH);

    tdu_rx u_rx (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .ev       (ev),
        .rx_level (s_rx_level),
        .res      (rx_res)
    );

    tdu_tx #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_tx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .ev        (ev),
        .push_data (s_push_data),
        .res       (tx_res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tx_level_reg <= tx_res.line;
            tx_busy_reg  <= tx_res.busy;
            rx_valid_reg <= rx_res.valid;
            rx_byte_reg  <= rx_res.data;
            edge_ok_reg  <= rx_res.edge_ok;
            push_ok_reg  <= tx_res.push_ok;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_tx_level      = tx_level_reg;
    assign m_tx_busy       = tx_busy_reg;
    assign m_rx_valid      = rx_valid_reg;
    assign m_rx_byte       = rx_byte_reg;
    assign m_edge_accepted = edge_ok_reg;
    assign m_push_accepted = push_ok_reg;

    a_accept_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted word gave no result");

    a_rx_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_operation != OP_TICK) |=> !m_rx_valid)
        else $error("rx byte delivered on a non-tick word");

    a_push_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_operation == OP_PUSH) |=> !m_edge_accepted)
        else $error("edge flag set on a push word");

    a_tick_no_push_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_operation != OP_PUSH) |=> !m_push_accepted)
        else $error("push flag set on a non-push word");

endmodule

`default_nettype wire

[tb/tb_tick_driven_uart_with_tx_queue.sv]
// tb_tick_driven_uart_with_tx_queue: self-checking testbench for the tick driven uart
// a cycle-free line model predicts every result word; random stimulus and stalls
// depends on tdu_pkg and tick_driven_uart_with_tx_queue
`timescale 1ns / 1ps

module tb_tick_driven_uart_with_tx_queue;
    import tdu_pkg::*;

    localparam logic [1:0] OP_NONE      = 2'd3;
    localparam logic [1:0] REG_UNUSED_A = 2'd2;
    localparam logic [1:0] REG_UNUSED_B = 2'd3;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 80;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [1:0] op;
        logic       lvl;
        logic [7:0] pdata;
        logic       drain;
    } uart_op_t;

    typedef struct packed {
        logic       tx_level;
        logic       tx_busy;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       edge_ok;
        logic       push_ok;
    } uart_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_DATA_BITS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_operation = OP_TICK;
    logic       s_rx_level = 1'b1;
    logic [7:0] s_push_data = '0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_tx_level;
    logic       m_tx_busy;
    logic       m_rx_valid;
    logic [7:0] m_rx_byte;
    logic       m_edge_accepted;
    logic       m_push_accepted;

    // line model state
    logic [3:0] nd_reg = DATA_BITS_RST;
    logic [1:0] ns_reg = STOP_BITS_RST;
    logic       rcv_armed = 1'b0;
    logic [3:0] rcv_count = '0;
    logic [7:0] rcv_sr = '0;
    logic [3:0] xmt_count = '0;
    logic [7:0] xmt_sr = BYTE_ONES;
    logic       xmt_line = 1'b1;
    logic       xmt_active = 1'b0;
    logic [7:0] txq_mem [FIFO_DEPTH_DEF];
    int         txq_rd = 0;
    int         txq_wr = 0;
    int         txq_cnt = 0;

    uart_op_t  uart_ops [$];
    uart_res_t results_due [$];
    uart_op_t  next_op;
    uart_res_t want;

    int  n_issued = 0;
    int  n_accepted = 0;
    int  n_results = 0;
    int  mismatches = 0;
    int  idle_pct = 0;
    int  s_gap = 0;
    int  m_gap = 0;
    int  quiet_cycles = 0;
    logic op_taken = 1'b0;

    logic [3:0] plan_nd   [PHASES] = '{4'd8, 4'd5, 4'd8, 4'd6, 4'd0, 4'd15, 4'd7, 4'd8};
    logic [3:0] plan_ns   [PHASES] = '{4'd1, 4'd2, 4'd6, 4'd1, 4'd0, 4'd3, 4'd14, 4'd1};
    int         plan_idle [PHASES] = '{25, 0, 35, 10, 50, 20, 15, 0};

    tick_driven_uart_with_tx_queue #(
        .FIFO_DEPTH(FIFO_DEPTH_DEF)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_rx_level     (s_rx_level),
        .s_push_data    (s_push_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tx_level     (m_tx_level),
        .m_tx_busy      (m_tx_busy),
        .m_rx_valid     (m_rx_valid),
        .m_rx_byte      (m_rx_byte),
        .m_edge_accepted(m_edge_accepted),
        .m_push_accepted(m_push_accepted)
    );

    always #5 aclk = ~aclk;

    function automatic int frame_data_bits();
        if (nd_reg < DATA_BITS_MIN) return DATA_BITS_MIN;
        if (nd_reg > DATA_BITS_MAX) return DATA_BITS_MAX;
        return nd_reg;
    endfunction

    function automatic int frame_stop_bits();
        if (ns_reg < STOP_BITS_MIN) return STOP_BITS_MIN;
        if (ns_reg > STOP_BITS_MAX) return STOP_BITS_MAX;
        return ns_reg;
    endfunction

    function automatic uart_res_t uart_advance(input logic [1:0] op, input logic lvl,
                                               input logic [7:0] pd);
        uart_res_t r;
        int nd;
        int frame;
        r = '0;
        nd = frame_data_bits();
        frame = 1 + nd + frame_stop_bits();
        case (op)
            OP_TICK: begin
                if (rcv_armed) begin
                    rcv_count = rcv_count + 4'd1;
                    if (rcv_count >= frame) begin
                        r.rx_valid = 1'b1;
                        r.rx_byte = rcv_sr >> (8 - nd);
                        rcv_armed = 1'b0;
                        rcv_count = '0;
                    end else if (rcv_count <= nd + 1) begin
                        rcv_sr = {lvl, rcv_sr[7:1]};
                    end
                end
                if (xmt_count == 0) begin
                    if (txq_cnt != 0) begin
                        xmt_sr = txq_mem[txq_rd];
                        txq_rd = (txq_rd + 1) % FIFO_DEPTH_DEF;
                        txq_cnt = txq_cnt - 1;
                        xmt_line = 1'b0;
                        xmt_active = 1'b1;
                        xmt_count = 4'd1;
                    end
                end else if (xmt_count <= frame - 1) begin
                    xmt_line = (xmt_count <= nd) ? xmt_sr[0] : 1'b1;
                    xmt_sr = {1'b1, xmt_sr[7:1]};
                    xmt_count = xmt_count + 4'd1;
                end else begin
                    xmt_line = 1'b1;
                    xmt_active = 1'b0;
                    xmt_count = '0;
                end
            end
            OP_EDGE: begin
                if (!rcv_armed) begin
                    rcv_armed = 1'b1;
                    rcv_count = '0;
                    rcv_sr = '0;
                    r.edge_ok = 1'b1;
                end
            end
            OP_PUSH: begin
                if (txq_cnt < FIFO_DEPTH_DEF) begin
                    txq_mem[txq_wr] = pd;
                    txq_wr = (txq_wr + 1) % FIFO_DEPTH_DEF;
                    txq_cnt = txq_cnt + 1;
                    r.push_ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.tx_level = xmt_line;
        r.tx_busy = xmt_active;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int exp_v);
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 field, n_results, got, exp_v);
        mismatches++;
    endtask

    // word driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || op_taken) begin
            if (s_gap != 0) begin
                s_gap = s_gap - 1;
                s_valid <= 1'b0;
            end else if (uart_ops.size() != 0 &&
                         (!uart_ops[0].drain || n_results >= n_accepted)) begin
                next_op = uart_ops.pop_front();
                s_valid <= 1'b1;
                s_operation <= next_op.op;
                s_rx_level <= next_op.lvl;
                s_push_data <= next_op.pdata;
                if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                    s_gap = $urandom_range(1, 6);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (m_gap != 0) begin
            m_gap = m_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                m_gap = $urandom_range(1, 6);
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            op_taken <= 1'b0;
        end else begin
            op_taken <= s_valid && s_ready;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_DATA_BITS)
                    nd_reg = cfg_data;
                else if (cfg_index == REG_STOP_BITS)
                    ns_reg = cfg_data[1:0];
            end
            if (s_valid && s_ready) begin
                results_due.push_back(uart_advance(s_operation, s_rx_level, s_push_data));
                n_accepted <= n_accepted + 1;
            end
            if (m_valid && m_ready) begin
                n_results <= n_results + 1;
                if (results_due.size() == 0) begin
                    report_mismatch("m_valid with no word due", 1, 0);
                end else begin
                    want = results_due.pop_front();
                    if (m_tx_level !== want.tx_level)
                        report_mismatch("tx_level", m_tx_level, want.tx_level);
                    if (m_tx_busy !== want.tx_busy)
                        report_mismatch("tx_busy", m_tx_busy, want.tx_busy);
                    if (m_rx_valid !== want.rx_valid)
                        report_mismatch("rx_valid", m_rx_valid, want.rx_valid);
                    if (m_rx_byte !== want.rx_byte)
                        report_mismatch("rx_byte", m_rx_byte, want.rx_byte);
                    if (m_edge_accepted !== want.edge_ok)
                        report_mismatch("edge_accepted", m_edge_accepted, want.edge_ok);
                    if (m_push_accepted !== want.push_ok)
                        report_mismatch("push_accepted", m_push_accepted, want.push_ok);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("tick_driven_uart_with_tx_queue regression: fail");
            $finish;
        end
    end

    task automatic add_word(input logic [1:0] op, input logic lvl, input logic [7:0] pd,
                            input logic drain);
        uart_op_t w;
        w.op = op;
        w.lvl = lvl;
        w.pdata = pd;
        w.drain = drain;
        uart_ops.push_back(w);
        n_issued++;
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (n_accepted != n_issued || n_results < n_accepted);
    endtask

    // tick until the receiver is at rest
    task automatic quiesce();
        wait_idle();
        while (rcv_armed) begin
            repeat (16) add_word(OP_TICK, 1'($urandom_range(0, 1)),
                                 8'($urandom_range(0, 255)), 1'b0);
            wait_idle();
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // edge, start bit, data lsb first, stop bits, with pushes and stray words mixed in
    task automatic send_frame(input logic [7:0] d, input logic drain);
        int nd;
        int ns;
        logic lvl;
        nd = frame_data_bits();
        ns = frame_stop_bits();
        add_word(OP_EDGE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), drain);
        for (int k = 0; k < 1 + nd + ns; k++) begin
            if ($urandom_range(0, 5) == 0)
                add_word(OP_PUSH, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
            if ($urandom_range(0, 29) == 0)
                add_word($urandom_range(0, 1) ? OP_EDGE : OP_NONE, 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)), 1'b0);
            lvl = (k == 0) ? 1'b0 : (k <= nd) ? d[k-1] : 1'b1;
            add_word(OP_TICK, lvl, 8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic random_burst();
        int r;
        int n;
        logic [7:0] d;
        logic drain;
        r = $urandom_range(0, 99);
        drain = ($urandom_range(0, 9) == 0);
        if (r < 60) begin
            if ($urandom_range(0, 7) == 0)
                d = $urandom_range(0, 1) ? 8'h00 : BYTE_ONES;
            else
                d = 8'($urandom_range(0, 255));
            send_frame(d, drain);
        end else if (r < 85) begin
            n = ($urandom_range(0, 9) == 0) ? FIFO_DEPTH_DEF + 2 : $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
                add_word(OP_PUSH, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         drain && k == 0);
        end else begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
                add_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)), drain && k == 0);
        end
    endtask

    initial begin
        int mark;
        idle_pct = plan_idle[0];
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_word(OP_NONE, 1'b1, BYTE_ONES, 1'b0);
        add_word(OP_EDGE, 1'b0, 8'h00, 1'b0);
        add_word(OP_EDGE, 1'b1, 8'h00, 1'b0);
        // one push more than the queue holds
        for (int k = 0; k <= FIFO_DEPTH_DEF; k++)
            add_word(OP_PUSH, k[0], (k == 0) ? 8'h00 : (k == 1) ? BYTE_ONES :
                     8'($urandom_range(0, 255)), 1'b0);
        add_word(OP_TICK, 1'b0, BYTE_ONES, 1'b0);
        add_word(OP_TICK, 1'b1, 8'h00, 1'b0);
        add_word(OP_NONE, 1'b0, 8'h00, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            quiesce();
            if (p != 0) begin
                write_reg(REG_DATA_BITS, plan_nd[p]);
                write_reg(REG_STOP_BITS, plan_ns[p]);
                if (p == 3) begin
                    write_reg(REG_UNUSED_A, 4'hF);
                    write_reg(REG_UNUSED_B, 4'h0);
                end
                @(negedge aclk);
                cfg_valid <= 1'b0;
            end
            idle_pct = plan_idle[p];
            mark = n_issued;
            while (n_issued - mark < PHASE_WORDS)
                random_burst();
        end

        wait_idle();
        repeat (4) @(posedge aclk);
        if (results_due.size() != 0)
            report_mismatch("words left over", results_due.size(), 0);
        if (mismatches == 0)
            $display("tick_driven_uart_with_tx_queue regression: pass");
        else
            $display("tick_driven_uart_with_tx_queue regression: fail");
        $finish;
    end

endmodule
